FILE: rtl/arpq_pkg.sv
// Shared types and constants of the address resolution pending queue.
package arpq_pkg;

    localparam int QUEUE_SLOTS_DEF = 32;
    localparam int CMD_DEPTH       = 2;

    localparam int ACTION_W = 2;
    localparam int HANDLE_W = 16;
    localparam int IP_W     = 32;
    localparam int QUEUE_W  = 16;
    localparam int MAC_W    = 48;
    localparam int BUDGET_W = 6;
    localparam int KIND_W   = 3;
    localparam int ENTRY_W  = HANDLE_W + IP_W + QUEUE_W;

    localparam logic [BUDGET_W-1:0] SEND_CAP = BUDGET_W'(32);

    typedef enum logic [ACTION_W-1:0] {
        ACT_ENQUEUE = 2'd0,
        ACT_DRAIN   = 2'd1,
        ACT_FLUSH   = 2'd2
    } t_action;

    typedef enum logic [KIND_W-1:0] {
        KIND_ENQUEUED   = 3'd0,
        KIND_EVICTED    = 3'd1,
        KIND_SEND       = 3'd2,
        KIND_FREED      = 3'd3,
        KIND_DRAIN_DONE = 3'd4,
        KIND_FLUSH_DONE = 3'd5
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVICT_RD,
        ST_EVICT_OUT,
        ST_ENQ,
        ST_WALK_RD,
        ST_WALK_OUT,
        ST_DONE
    } t_state;

    typedef struct packed {
        t_action               action;
        logic [HANDLE_W-1:0]   handle;
        logic [IP_W-1:0]       ip;
        logic [QUEUE_W-1:0]    queue;
        logic [MAC_W-1:0]      mac;
        logic [BUDGET_W-1:0]   budget;
    } t_cmd;

    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_cmd_link;

    typedef struct packed {
        t_kind                 kind;
        logic [HANDLE_W-1:0]   handle;
        logic [QUEUE_W-1:0]    queue;
        logic [MAC_W-1:0]      mac;
        logic [BUDGET_W-1:0]   count;
        logic                  last;
    } t_rsp;

endpackage

FILE: rtl/arpq_if.sv
// Request and result channel interfaces of the pending queue.
interface arpq_in_if;
    logic                          valid;
    logic                          ready;
    logic [arpq_pkg::ACTION_W-1:0] action;
    logic [arpq_pkg::HANDLE_W-1:0] packet_handle;
    logic [arpq_pkg::IP_W-1:0]     wait_addr;
    logic [arpq_pkg::QUEUE_W-1:0]  txq_id;
    logic [arpq_pkg::IP_W-1:0]     learned_addr;
    logic [arpq_pkg::MAC_W-1:0]    resolved_mac;
    logic [arpq_pkg::BUDGET_W-1:0] send_budget;

    modport source (
        output valid, action, packet_handle, wait_addr, txq_id,
               learned_addr, resolved_mac, send_budget,
        input  ready
    );
    modport sink (
        input  valid, action, packet_handle, wait_addr, txq_id,
               learned_addr, resolved_mac, send_budget,
        output ready
    );
endinterface

interface arpq_out_if;
    logic                          valid;
    logic                          ready;
    logic [arpq_pkg::KIND_W-1:0]   kind;
    logic [arpq_pkg::HANDLE_W-1:0] out_handle;
    logic [arpq_pkg::QUEUE_W-1:0]  out_queue;
    logic [arpq_pkg::MAC_W-1:0]    dest_mac;
    logic [arpq_pkg::BUDGET_W-1:0] sent_count;
    logic                          last;

    modport source (
        output valid, kind, out_handle, out_queue, dest_mac, sent_count, last,
        input  ready
    );
    modport sink (
        input  valid, kind, out_handle, out_queue, dest_mac, sent_count, last,
        output ready
    );
endinterface

FILE: rtl/arpq_front.sv
// Front end: accepts items, classifies them into commands and queues them; items with an unknown action are dropped.
module arpq_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    arpq_in_if.sink             i_req,
    input  logic                i_pop,
    output arpq_pkg::t_cmd_link o_cmd
);
    localparam int PW   = (arpq_pkg::CMD_DEPTH > 1) ? $clog2(arpq_pkg::CMD_DEPTH) : 1;
    localparam int CNTW = $clog2(arpq_pkg::CMD_DEPTH + 1);
    localparam logic [CNTW-1:0] FULL    = CNTW'(arpq_pkg::CMD_DEPTH);
    localparam logic [PW-1:0]   PTR_TOP = PW'(arpq_pkg::CMD_DEPTH - 1);

    arpq_pkg::t_cmd  r_buf [arpq_pkg::CMD_DEPTH];
    logic [PW-1:0]   r_wr_ptr;
    logic [PW-1:0]   r_rd_ptr;
    logic [CNTW-1:0] r_fill;

    arpq_pkg::t_cmd  n_cmd;
    logic            push_ok;
    logic            accept;
    logic            push;

    assign i_req.ready = (r_fill != FULL);
    assign accept      = i_req.valid && i_req.ready;
    assign push        = accept && push_ok;

    always_comb begin
        n_cmd        = '0;
        push_ok      = 1'b1;
        n_cmd.handle = i_req.packet_handle;
        n_cmd.queue  = i_req.txq_id;
        n_cmd.mac    = i_req.resolved_mac;
        n_cmd.budget = (i_req.send_budget > arpq_pkg::SEND_CAP) ? arpq_pkg::SEND_CAP
                                                                  : i_req.send_budget;
        unique case (arpq_pkg::t_action'(i_req.action))
            arpq_pkg::ACT_ENQUEUE: begin
                n_cmd.action = arpq_pkg::ACT_ENQUEUE;
                n_cmd.ip     = i_req.wait_addr;
            end
            arpq_pkg::ACT_DRAIN: begin
                n_cmd.action = arpq_pkg::ACT_DRAIN;
                n_cmd.ip     = i_req.learned_addr;
            end
            arpq_pkg::ACT_FLUSH: begin
                n_cmd.action = arpq_pkg::ACT_FLUSH;
            end
            default: begin
                push_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr_ptr] <= n_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_TOP) ? '0 : r_wr_ptr + PW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_TOP) ? '0 : r_rd_ptr + PW'(1);
            end
            unique case ({push, i_pop})
                2'b10:   r_fill <= r_fill + CNTW'(1);
                2'b01:   r_fill <= r_fill - CNTW'(1);
                default: r_fill <= r_fill;
            endcase
        end
    end

    assign o_cmd.valid = (r_fill != '0);
    assign o_cmd.cmd   = r_buf[r_rd_ptr];

endmodule

FILE: rtl/arpq_back.sv
// Back end: entry memory, command sequencer and result register.
module arpq_back #(
    parameter int QUEUE_SLOTS = arpq_pkg::QUEUE_SLOTS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  arpq_pkg::t_cmd_link i_cmd,
    output logic                o_pop,
    arpq_out_if.source          o_rsp
);
    localparam int SW    = $clog2(QUEUE_SLOTS);
    localparam int SW1   = SW + 1;
    localparam int CW    = $clog2(QUEUE_SLOTS + 1);
    localparam int DEPTH = 2 * QUEUE_SLOTS;
    localparam int AW    = $clog2(DEPTH);
    localparam int EW    = arpq_pkg::ENTRY_W;
    localparam logic [CW-1:0]  FULL     = CW'(QUEUE_SLOTS);
    localparam logic [SW1-1:0] SUM_WRAP = SW1'(QUEUE_SLOTS);
    localparam logic [AW-1:0]  BANK_OFS = AW'(QUEUE_SLOTS);

    function automatic logic [SW-1:0] wrap_slot(logic [SW-1:0] base, logic [CW-1:0] ofs);
        logic [SW1-1:0] sum;
        sum = SW1'(base) + SW1'(ofs);
        if (sum >= SUM_WRAP) begin
            sum = sum - SUM_WRAP;
        end
        return sum[SW-1:0];
    endfunction

    function automatic logic [AW-1:0] addr_of(logic bank, logic [SW-1:0] slot);
        return (bank ? BANK_OFS : '0) + AW'(slot);
    endfunction

    arpq_pkg::t_state              r_state, n_state;
    arpq_pkg::t_cmd                r_cmd, n_cmd;
    logic [SW-1:0]                 r_head, n_head;
    logic [CW-1:0]                 r_count, n_count;
    logic                          r_bank, n_bank;
    logic [CW-1:0]                 r_idx, n_idx;
    logic [CW-1:0]                 r_kept, n_kept;
    logic [arpq_pkg::BUDGET_W-1:0] r_sent, n_sent;
    logic [EW-1:0]                 r_mem [DEPTH];
    logic [EW-1:0]                 r_rd_data;
    logic                          r_out_valid;
    arpq_pkg::t_rsp                r_out, n_rsp;

    logic          rd_en;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [EW-1:0] wr_data;
    logic          emit;
    logic          out_free;
    logic          is_flush;
    logic          is_match;
    logic          walk_more;
    logic          step_ok;

    logic [arpq_pkg::HANDLE_W-1:0] rd_handle;
    logic [arpq_pkg::IP_W-1:0]     rd_ip;
    logic [arpq_pkg::QUEUE_W-1:0]  rd_queue;

    assign rd_handle = r_rd_data[arpq_pkg::HANDLE_W-1:0];
    assign rd_ip     = r_rd_data[arpq_pkg::HANDLE_W +: arpq_pkg::IP_W];
    assign rd_queue  = r_rd_data[EW-1 -: arpq_pkg::QUEUE_W];

    assign out_free  = !r_out_valid || o_rsp.ready;
    assign is_flush  = (r_cmd.action == arpq_pkg::ACT_FLUSH);
    assign is_match  = (r_cmd.action == arpq_pkg::ACT_DRAIN) && (rd_ip == r_cmd.ip)
                       && (r_sent < r_cmd.budget);
    assign walk_more = (r_idx < r_count);
    assign step_ok   = !(is_flush || is_match) || out_free;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            arpq_pkg::ST_IDLE: begin
                if (i_cmd.valid) begin
                    if (i_cmd.cmd.action == arpq_pkg::ACT_ENQUEUE) begin
                        n_state = (r_count == FULL) ? arpq_pkg::ST_EVICT_RD
                                                    : arpq_pkg::ST_ENQ;
                    end else begin
                        n_state = arpq_pkg::ST_WALK_RD;
                    end
                end
            end
            arpq_pkg::ST_EVICT_RD:  n_state = arpq_pkg::ST_EVICT_OUT;
            arpq_pkg::ST_EVICT_OUT: if (out_free) n_state = arpq_pkg::ST_ENQ;
            arpq_pkg::ST_ENQ:       if (out_free) n_state = arpq_pkg::ST_IDLE;
            arpq_pkg::ST_WALK_RD: begin
                n_state = walk_more ? arpq_pkg::ST_WALK_OUT : arpq_pkg::ST_DONE;
            end
            arpq_pkg::ST_WALK_OUT:  if (step_ok) n_state = arpq_pkg::ST_WALK_RD;
            arpq_pkg::ST_DONE:      if (out_free) n_state = arpq_pkg::ST_IDLE;
            default:                n_state = arpq_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_pop   = 1'b0;
        rd_en   = 1'b0;
        rd_addr = '0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = {r_cmd.queue, r_cmd.ip, r_cmd.handle};
        emit    = 1'b0;
        n_rsp   = '0;
        n_cmd   = r_cmd;
        n_head  = r_head;
        n_count = r_count;
        n_bank  = r_bank;
        n_idx   = r_idx;
        n_kept  = r_kept;
        n_sent  = r_sent;
        unique case (r_state)
            arpq_pkg::ST_IDLE: begin
                if (i_cmd.valid) begin
                    o_pop  = 1'b1;
                    n_cmd  = i_cmd.cmd;
                    n_idx  = '0;
                    n_kept = '0;
                    n_sent = '0;
                end
            end
            arpq_pkg::ST_EVICT_RD: begin
                rd_en   = 1'b1;
                rd_addr = addr_of(r_bank, r_head);
            end
            arpq_pkg::ST_EVICT_OUT: begin
                if (out_free) begin
                    emit         = 1'b1;
                    n_rsp.kind   = arpq_pkg::KIND_EVICTED;
                    n_rsp.handle = rd_handle;
                    n_head       = wrap_slot(r_head, CW'(1));
                    n_count      = FULL - CW'(1);
                end
            end
            arpq_pkg::ST_ENQ: begin
                if (out_free) begin
                    wr_en        = 1'b1;
                    wr_addr      = addr_of(r_bank, wrap_slot(r_head, r_count));
                    n_count      = r_count + CW'(1);
                    emit         = 1'b1;
                    n_rsp.kind   = arpq_pkg::KIND_ENQUEUED;
                    n_rsp.handle = r_cmd.handle;
                    n_rsp.last   = 1'b1;
                end
            end
            arpq_pkg::ST_WALK_RD: begin
                if (walk_more) begin
                    rd_en   = 1'b1;
                    rd_addr = addr_of(r_bank, wrap_slot(r_head, r_idx));
                end
            end
            arpq_pkg::ST_WALK_OUT: begin
                if (is_flush) begin
                    if (out_free) begin
                        emit         = 1'b1;
                        n_rsp.kind   = arpq_pkg::KIND_FREED;
                        n_rsp.handle = rd_handle;
                        n_idx        = r_idx + CW'(1);
                    end
                end else if (is_match) begin
                    if (out_free) begin
                        emit         = 1'b1;
                        n_rsp.kind   = arpq_pkg::KIND_SEND;
                        n_rsp.handle = rd_handle;
                        n_rsp.queue  = rd_queue;
                        n_rsp.mac    = r_cmd.mac;
                        n_sent       = r_sent + arpq_pkg::BUDGET_W'(1);
                        n_idx        = r_idx + CW'(1);
                    end
                end else begin
                    // kept entries are compacted into the other bank
                    wr_en   = 1'b1;
                    wr_addr = addr_of(!r_bank, r_kept[SW-1:0]);
                    wr_data = r_rd_data;
                    n_kept  = r_kept + CW'(1);
                    n_idx   = r_idx + CW'(1);
                end
            end
            arpq_pkg::ST_DONE: begin
                if (out_free) begin
                    emit       = 1'b1;
                    n_rsp.last = 1'b1;
                    n_head     = '0;
                    if (is_flush) begin
                        n_rsp.kind = arpq_pkg::KIND_FLUSH_DONE;
                        n_count    = '0;
                    end else begin
                        n_rsp.kind  = arpq_pkg::KIND_DRAIN_DONE;
                        n_rsp.count = r_sent;
                        n_count     = r_kept;
                        n_bank      = !r_bank;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        if (emit) begin
            r_out <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= arpq_pkg::ST_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_bank      <= 1'b0;
            r_idx       <= '0;
            r_kept      <= '0;
            r_sent      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_count <= n_count;
            r_bank  <= n_bank;
            r_idx   <= n_idx;
            r_kept  <= n_kept;
            r_sent  <= n_sent;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.kind       = r_out.kind;
    assign o_rsp.out_handle = r_out.handle;
    assign o_rsp.out_queue  = r_out.queue;
    assign o_rsp.dest_mac   = r_out.mac;
    assign o_rsp.sent_count = r_out.count;
    assign o_rsp.last       = r_out.last;

endmodule

FILE: rtl/address_resolution_pending_queue_core.sv
// Top level of the address resolution pending queue.
// An enqueue writes the entry and registers its result; when the queue is full the oldest
// entry is first read and then evicted with its own result. Drain and flush read each
// stored entry in turn, paced by the single entry memory read port; a stalled result holds
// the walk at entries that produce a result.
// Reset (synchronous, active low) empties the queue; entry memory is not cleared.
module address_resolution_pending_queue_core #(
    parameter int QUEUE_SLOTS = arpq_pkg::QUEUE_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    arpq_in_if.sink     i_req,
    arpq_out_if.source  o_rsp
);
    arpq_pkg::t_cmd_link cmd_link;
    logic                cmd_pop;

    arpq_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_pop   (cmd_pop),
        .o_cmd   (cmd_link)
    );

    arpq_back #(
        .QUEUE_SLOTS (QUEUE_SLOTS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_link),
        .o_pop   (cmd_pop),
        .o_rsp   (o_rsp)
    );

endmodule

FILE: rtl/arpq_checker.sv
// Port-level checker of the pending queue and its bind to the top level.
module arpq_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic [arpq_pkg::KIND_W-1:0]   i_kind,
    input logic [arpq_pkg::HANDLE_W-1:0] i_handle,
    input logic [arpq_pkg::QUEUE_W-1:0]  i_queue,
    input logic [arpq_pkg::MAC_W-1:0]    i_mac,
    input logic [arpq_pkg::BUDGET_W-1:0] i_count,
    input logic                          i_last
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_kind)
            && $stable(i_handle) && $stable(i_last))
        else $error("result changed while stalled");

    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_last == (i_kind == arpq_pkg::KIND_ENQUEUED
            || i_kind == arpq_pkg::KIND_DRAIN_DONE
            || i_kind == arpq_pkg::KIND_FLUSH_DONE))
        else $error("last flag does not fit result kind");

    a_send_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_kind != arpq_pkg::KIND_SEND |-> i_queue == '0 && i_mac == '0)
        else $error("send fields set on a non-send item");

    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> i_count <= arpq_pkg::SEND_CAP
            && (i_kind == arpq_pkg::KIND_DRAIN_DONE || i_count == '0))
        else $error("bad sent count");

    a_reset_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_rsp_valid)
        else $error("result valid right after reset");

endmodule

bind address_resolution_pending_queue_core arpq_checker u_arpq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_kind      (o_rsp.kind),
    .i_handle    (o_rsp.out_handle),
    .i_queue     (o_rsp.out_queue),
    .i_mac       (o_rsp.dest_mac),
    .i_count     (o_rsp.sent_count),
    .i_last      (o_rsp.last)
);
